/* rtl/stha_pkg.sv */
// Shared types and constants for the spectrum trace hold, average and peak core.
// No dependencies; imported by stha_div and spectrum_trace_hold_average_peak_core.
package stha_pkg;

    // Bin store geometry
    localparam int NUM_BINS = 1024;
    localparam int BIN_W    = $clog2(NUM_BINS);

    // Level format: signed 1/64 dB
    localparam int LVL_W = 16;
    localparam logic signed [LVL_W-1:0] LVL_MIN = 16'sh8000;
    localparam logic signed [LVL_W-1:0] LVL_MAX = 16'sh7FFF;

    // Averaging weight and divider widths
    localparam int          CNT_W   = 11;
    localparam logic [10:0] AVG_MAX = 11'd1024;
    localparam int          DVD_W   = 27;
    localparam int          QUO_W   = 16;

    // Trace mode codes
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_RAW    = 3'd1;
    localparam logic [2:0] MODE_MAX    = 3'd2;
    localparam logic [2:0] MODE_MIN    = 3'd3;
    localparam logic [2:0] MODE_MINMAX = 3'd4;
    localparam logic [2:0] MODE_AVG    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRACE_MODE = 2'd0;
    localparam logic [1:0] CFG_AVG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_PEAK_EN    = 2'd2;

    // Divider request: offset running-average numerator and weight
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

/* rtl/stha_div.sv */
// Restoring unsigned divider, one quotient bit per cycle, for the average mode.
// Depends on stha_pkg (div_req_t and widths).
module stha_div
    import stha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [CNT_W-1:0] rem_reg;
    logic [QUO_W-1:0] dvd_reg;
    logic [CNT_W-1:0] dsr_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CNT_W:0]   trial;
    logic             fits;
    logic [CNT_W:0]   diff;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, dvd_reg[QUO_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // Shift quotient bits in as dividend bits shift out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // Upper dividend bits are already below the divisor
                rem_reg  <= req.dividend[DVD_W-1:QUO_W];
                dvd_reg  <= req.dividend[QUO_W-1:0];
                dsr_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                dvd_reg <= {dvd_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* rtl/spectrum_trace_hold_average_peak_core.sv */
// Spectrum trace hold / average / peak core. Takes one bin beat at a time. In every mode
// but average a bin passes through the read and finish states to its result; in average
// mode it also passes through the prep and divide states, where the bit-serial divider
// forms floor(sum / n). A result waiting in the output register does not block the next
// bin, but the bin after it waits until that result is taken. After reset the two
// 1024-entry bin stores are swept to their reset levels, one entry per cycle, so no bin is
// accepted until the sweep ends; configuration writes are taken during that sweep.
// Depends on stha_pkg and stha_div.
module spectrum_trace_hold_average_peak_core
    import stha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // Bin input: tdata = bin_min_level[15:0], bin_max_level[31:16]; tlast = sweep_last
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Result output: tdata = bin_number[9:0], trace_a_value[25:10], trace_b_value[41:26],
    // peak_bin[51:42], peak_level[67:52], zero[71:68]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    // tuser = trace_a_visible[0], trace_b_visible[1], peak_valid[2]
    output logic [2:0]  m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    // Configuration registers
    logic [2:0]       mode_reg;
    logic [CNT_W-1:0] avg_cnt_reg;
    logic             peak_en_reg;

    // Store sweep after reset
    logic             clearing_reg;
    logic [BIN_W-1:0] clr_addr_reg;

    // Bin stores
    logic [LVL_W-1:0] max_mem [NUM_BINS];
    logic [LVL_W-1:0] min_mem [NUM_BINS];
    logic signed [LVL_W-1:0] rd_max_reg;
    logic signed [LVL_W-1:0] rd_min_reg;

    // Item and working registers
    state_t                  state_reg;
    logic [BIN_W-1:0]        pos_reg;
    logic signed [LVL_W-1:0] m_reg;
    logic signed [LVL_W-1:0] x_reg;
    logic                    last_reg;
    logic signed [LVL_W-1:0] nmax_reg;
    logic signed [LVL_W-1:0] nmin_reg;
    logic signed [LVL_W-1:0] a_reg;
    logic signed [LVL_W-1:0] b_reg;
    logic                    avis_reg;
    logic                    bvis_reg;
    logic signed [LVL_W-1:0] cand_reg;
    logic signed [DVD_W-1:0] prod_reg;
    logic [BIN_W-1:0]        best_bin_reg;
    logic signed [LVL_W-1:0] best_lvl_reg;

    // Output register
    logic                    m_valid_reg;
    logic [9:0]              o_bin_reg;
    logic signed [LVL_W-1:0] o_a_reg;
    logic signed [LVL_W-1:0] o_b_reg;
    logic                    o_avis_reg;
    logic                    o_bvis_reg;
    logic                    o_pvalid_reg;
    logic [9:0]              o_pbin_reg;
    logic signed [LVL_W-1:0] o_plvl_reg;

    // Combinational signals
    logic                    accept;
    logic                    out_free;
    logic                    fin_go;
    logic                    mem_we;
    logic [BIN_W-1:0]        mem_wa;
    logic [LVL_W-1:0]        mem_wmax;
    logic [LVL_W-1:0]        mem_wmin;
    logic [CNT_W-1:0]        n_clamp;
    logic signed [CNT_W-1:0] nm1_s;
    logic [DVD_W:0]          u_sum;
    div_req_t                div_req;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;
    logic signed [LVL_W-1:0] avg_val;
    logic signed [LVL_W-1:0] c_max;
    logic signed [LVL_W-1:0] c_min;
    logic signed [LVL_W-1:0] c_a;
    logic signed [LVL_W-1:0] c_b;
    logic                    c_avis;
    logic                    c_bvis;
    logic                    new_best;
    logic [BIN_W-1:0]        best_bin_next;
    logic signed [LVL_W-1:0] best_lvl_next;
    logic                    pvalid;

    // Handshake
    assign s_axis_tready = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign fin_go        = (state_reg == ST_FIN) && out_free;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RAW;
            avg_cnt_reg <= 11'd1;
            peak_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRACE_MODE: mode_reg    <= cfg_data[2:0];
                CFG_AVG_COUNT:  avg_cnt_reg <= cfg_data;
                CFG_PEAK_EN:    peak_en_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Sweep the stores to their reset levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Select the store write: reset sweep or write-back of the finished bin
    always_comb
    begin
        mem_we   = clearing_reg || fin_go;
        mem_wa   = clearing_reg ? clr_addr_reg : pos_reg;
        mem_wmax = clearing_reg ? LVL_MIN : nmax_reg;
        mem_wmin = clearing_reg ? LVL_MAX : nmin_reg;
    end

    // Store ports: one write and one registered read per store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            max_mem[mem_wa] <= mem_wmax;
            min_mem[mem_wa] <= mem_wmin;
        end
        if (accept)
        begin
            rd_max_reg <= max_mem[pos_reg];
            rd_min_reg <= min_mem[pos_reg];
        end
    end

    // Clamp the averaging weight to 1..1024
    always_comb
    begin
        if (avg_cnt_reg == '0)
        begin
            n_clamp = 11'd1;
        end
        else if (avg_cnt_reg > AVG_MAX)
        begin
            n_clamp = AVG_MAX;
        end
        else
        begin
            n_clamp = avg_cnt_reg;
        end
        nm1_s = $signed(n_clamp - 11'd1);
    end

    // Offset numerator: hold*(n-1) + x + 32768*n is never negative
    always_comb
    begin
        u_sum = {prod_reg[DVD_W-1], prod_reg}
              + {{(DVD_W + 1 - LVL_W){x_reg[LVL_W-1]}}, x_reg}
              + {2'b00, n_clamp, 15'd0};
        div_req.start    = (state_reg == ST_PREP);
        div_req.dividend = u_sum[DVD_W-1:0];
        div_req.divisor  = n_clamp;
    end

    stha_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Remove the offset from the quotient
    assign avg_val = $signed(div_quo ^ 16'h8000);

    // Update the holds per trace mode
    always_comb
    begin
        c_max  = x_reg;
        c_min  = rd_min_reg;
        c_a    = '0;
        c_b    = '0;
        c_avis = 1'b1;
        c_bvis = 1'b0;
        case (mode_reg)
            MODE_RAW:
            begin
                c_a = x_reg;
            end
            MODE_MAX:
            begin
                c_max = (x_reg > rd_max_reg) ? x_reg : rd_max_reg;
                c_a   = c_max;
            end
            MODE_MIN:
            begin
                c_min = (m_reg < rd_min_reg) ? m_reg : rd_min_reg;
                c_a   = c_min;
            end
            MODE_MINMAX:
            begin
                c_max  = (x_reg > rd_max_reg) ? x_reg : rd_max_reg;
                c_min  = (m_reg < rd_min_reg) ? m_reg : rd_min_reg;
                c_a    = c_max;
                c_b    = c_min;
                c_bvis = 1'b1;
            end
            MODE_AVG:
            begin
                c_max = rd_max_reg;
            end
            default:
            begin
                c_avis = 1'b0;
            end
        endcase
    end

    // Peak search: restart at bin 0, strict greater replaces
    always_comb
    begin
        new_best      = (pos_reg == '0) || (cand_reg > best_lvl_reg);
        best_bin_next = new_best ? pos_reg : best_bin_reg;
        best_lvl_next = new_best ? cand_reg : best_lvl_reg;
        pvalid        = last_reg && peak_en_reg;
    end

    // Sequence one bin through read, optional divide, write-back and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            best_bin_reg <= '0;
            best_lvl_reg <= '0;
            m_reg        <= '0;
            x_reg        <= '0;
            last_reg     <= 1'b0;
            nmax_reg     <= '0;
            nmin_reg     <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            avis_reg     <= 1'b0;
            bvis_reg     <= 1'b0;
            cand_reg     <= '0;
            prod_reg     <= '0;
            m_valid_reg  <= 1'b0;
            o_bin_reg    <= '0;
            o_a_reg      <= '0;
            o_b_reg      <= '0;
            o_avis_reg   <= 1'b0;
            o_bvis_reg   <= 1'b0;
            o_pvalid_reg <= 1'b0;
            o_pbin_reg   <= '0;
            o_plvl_reg   <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one loads in the same cycle
            if (m_valid_reg && m_axis_tready && !fin_go)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        m_reg     <= $signed(s_axis_tdata[15:0]);
                        x_reg     <= $signed(s_axis_tdata[31:16]);
                        last_reg  <= s_axis_tlast;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    nmax_reg  <= c_max;
                    nmin_reg  <= c_min;
                    a_reg     <= c_a;
                    b_reg     <= c_b;
                    avis_reg  <= c_avis;
                    bvis_reg  <= c_bvis;
                    cand_reg  <= x_reg;
                    prod_reg  <= rd_max_reg * nm1_s;
                    state_reg <= (mode_reg == MODE_AVG) ? ST_PREP : ST_FIN;
                end
                ST_PREP:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        nmax_reg  <= avg_val;
                        a_reg     <= avg_val;
                        cand_reg  <= avg_val;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        best_bin_reg <= best_bin_next;
                        best_lvl_reg <= best_lvl_next;
                        m_valid_reg  <= 1'b1;
                        o_bin_reg    <= 10'(pos_reg);
                        o_a_reg      <= a_reg;
                        o_b_reg      <= b_reg;
                        o_avis_reg   <= avis_reg;
                        o_bvis_reg   <= bvis_reg;
                        o_pvalid_reg <= pvalid;
                        o_pbin_reg   <= pvalid ? 10'(best_bin_next) : 10'd0;
                        o_plvl_reg   <= pvalid ? best_lvl_next : '0;
                        // Advance the bin position, wrap at sweep end or store end
                        if (last_reg || pos_reg == BIN_W'(NUM_BINS - 1))
                        begin
                            pos_reg <= '0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the result beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, o_plvl_reg, o_pbin_reg, o_b_reg, o_a_reg, o_bin_reg};
    assign m_axis_tuser  = {o_pvalid_reg, o_bvis_reg, o_avis_reg};

    // No bin is taken while the stores are being swept
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("bin accepted during store sweep");

    // A store write outside the sweep comes only from a finishing bin
    a_write_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clearing_reg) |-> (state_reg == ST_FIN))
        else $error("store written outside write-back");

    // The divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // Peak fields are zero unless a peak is reported
    a_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !o_pvalid_reg) |-> (o_pbin_reg == 10'd0 && o_plvl_reg == '0))
        else $error("peak fields set without peak report");

    // A visible trace b always comes with a visible trace a
    a_b_implies_a: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && o_bvis_reg) |-> o_avis_reg)
        else $error("trace b visible without trace a");

endmodule
